>>> hdl/xml_entity_decoder_defines.svh
// Assertion macros used by the entity decoder front end, xed_decode.
// Requires clk_i and rst_ni in the scope of each use.
`ifndef XML_ENTITY_DECODER_DEFINES_SVH
`define XML_ENTITY_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define XED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define XED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/xed_pkg.sv
// Package for the XML entity decoder: trie node codes, character constants,
// the burst descriptor type and the trie and held-text lookup functions.
`timescale 1ns / 1ps

package xed_pkg;

  localparam int unsigned UnitW     = 16;
  localparam int unsigned NodeW     = 4;
  localparam int unsigned DescDepth = 4;
  localparam int unsigned DescPtrW  = $clog2(DescDepth);
  localparam int unsigned DescCntW  = $clog2(DescDepth + 1);

  // Trie nodes: idle, lone ampersand, then one node per held prefix.
  localparam logic [NodeW-1:0] N_IDLE = 4'd0;
  localparam logic [NodeW-1:0] N_AMP  = 4'd1;
  localparam logic [NodeW-1:0] N_A    = 4'd2;
  localparam logic [NodeW-1:0] N_AM   = 4'd3;
  localparam logic [NodeW-1:0] N_AMPL = 4'd4;
  localparam logic [NodeW-1:0] N_AP   = 4'd5;
  localparam logic [NodeW-1:0] N_APO  = 4'd6;
  localparam logic [NodeW-1:0] N_APOS = 4'd7;
  localparam logic [NodeW-1:0] N_G    = 4'd8;
  localparam logic [NodeW-1:0] N_GT   = 4'd9;
  localparam logic [NodeW-1:0] N_L    = 4'd10;
  localparam logic [NodeW-1:0] N_LT   = 4'd11;
  localparam logic [NodeW-1:0] N_Q    = 4'd12;
  localparam logic [NodeW-1:0] N_QU   = 4'd13;
  localparam logic [NodeW-1:0] N_QUO  = 4'd14;
  localparam logic [NodeW-1:0] N_QUOT = 4'd15;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LT_T  = 8'h74;
  localparam logic [7:0] CH_LU    = 8'h75;

  // One burst of results: flush of an old prefix, one plain or decoded unit, flush of
  // the prefix left open at end of text. A zero node means no flush.
  typedef struct packed {
    logic             eot;
    logic [NodeW-1:0] f2_node;
    logic [UnitW-1:0] mid_unit;
    logic             mid_en;
    logic [NodeW-1:0] f1_node;
  } desc_t;

  typedef struct packed {
    logic             hit;
    logic             done;
    logic [NodeW-1:0] nxt;
    logic [7:0]       emit;
  } step_t;

  function automatic logic is_ch(logic [UnitW-1:0] c, logic [7:0] ch);
    return c == {8'h00, ch};
  endfunction

  function automatic step_t trie_step(logic [NodeW-1:0] node, logic [UnitW-1:0] c);
    step_t s;
    s = '0;
    unique case (node)
      N_AMP: begin
        if (is_ch(c, CH_LA)) begin
          s.hit = 1'b1; s.nxt = N_A;
        end else if (is_ch(c, CH_LG)) begin
          s.hit = 1'b1; s.nxt = N_G;
        end else if (is_ch(c, CH_LL)) begin
          s.hit = 1'b1; s.nxt = N_L;
        end else if (is_ch(c, CH_LQ)) begin
          s.hit = 1'b1; s.nxt = N_Q;
        end
      end
      N_A: begin
        if (is_ch(c, CH_LM)) begin
          s.hit = 1'b1; s.nxt = N_AM;
        end else if (is_ch(c, CH_LP)) begin
          s.hit = 1'b1; s.nxt = N_AP;
        end
      end
      N_AM:   if (is_ch(c, CH_LP))   begin s.hit = 1'b1; s.nxt = N_AMPL; end
      N_AP:   if (is_ch(c, CH_LO))   begin s.hit = 1'b1; s.nxt = N_APO;  end
      N_APO:  if (is_ch(c, CH_LS))   begin s.hit = 1'b1; s.nxt = N_APOS; end
      N_G:    if (is_ch(c, CH_LT_T)) begin s.hit = 1'b1; s.nxt = N_GT;   end
      N_L:    if (is_ch(c, CH_LT_T)) begin s.hit = 1'b1; s.nxt = N_LT;   end
      N_Q:    if (is_ch(c, CH_LU))   begin s.hit = 1'b1; s.nxt = N_QU;   end
      N_QU:   if (is_ch(c, CH_LO))   begin s.hit = 1'b1; s.nxt = N_QUO;  end
      N_QUO:  if (is_ch(c, CH_LT_T)) begin s.hit = 1'b1; s.nxt = N_QUOT; end
      N_AMPL: if (is_ch(c, CH_SEMI)) begin s.hit = 1'b1; s.done = 1'b1; s.emit = CH_AMP;  end
      N_APOS: if (is_ch(c, CH_SEMI)) begin s.hit = 1'b1; s.done = 1'b1; s.emit = CH_APOS; end
      N_GT:   if (is_ch(c, CH_SEMI)) begin s.hit = 1'b1; s.done = 1'b1; s.emit = CH_GT;   end
      N_LT:   if (is_ch(c, CH_SEMI)) begin s.hit = 1'b1; s.done = 1'b1; s.emit = CH_LT;   end
      N_QUOT: if (is_ch(c, CH_SEMI)) begin s.hit = 1'b1; s.done = 1'b1; s.emit = CH_QUOT; end
      default: s = '0;
    endcase
    return s;
  endfunction

  // Letters held after the ampersand, first letter in the low byte.
  function automatic logic [31:0] held_word(logic [NodeW-1:0] node);
    logic [31:0] w;
    w = '0;
    unique case (node)
      N_A:     w = {24'h0, CH_LA};
      N_AM:    w = {16'h0, CH_LM, CH_LA};
      N_AMPL:  w = {8'h0, CH_LP, CH_LM, CH_LA};
      N_AP:    w = {16'h0, CH_LP, CH_LA};
      N_APO:   w = {8'h0, CH_LO, CH_LP, CH_LA};
      N_APOS:  w = {CH_LS, CH_LO, CH_LP, CH_LA};
      N_G:     w = {24'h0, CH_LG};
      N_GT:    w = {16'h0, CH_LT_T, CH_LG};
      N_L:     w = {24'h0, CH_LL};
      N_LT:    w = {16'h0, CH_LT_T, CH_LL};
      N_Q:     w = {24'h0, CH_LQ};
      N_QU:    w = {16'h0, CH_LU, CH_LQ};
      N_QUO:   w = {8'h0, CH_LO, CH_LU, CH_LQ};
      N_QUOT:  w = {CH_LT_T, CH_LO, CH_LU, CH_LQ};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] held_len(logic [NodeW-1:0] node);
    logic [2:0] n;
    n = 3'd0;
    unique case (node)
      N_A, N_G, N_L, N_Q:                   n = 3'd1;
      N_AM, N_AP, N_GT, N_LT, N_QU:         n = 3'd2;
      N_AMPL, N_APO, N_QUO:                 n = 3'd3;
      N_APOS, N_QUOT:                       n = 3'd4;
      default:                              n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/xml_entity_decoder.sv
// An accepted word is registered in the burst queue, then in the serialiser.
// Throughput: one input word a cycle while each word gives at most one result and
// the receiver is ready; the serialiser moves one output word a cycle while it is.
// A word with a failed entity gives up to ten results; a four-deep burst queue
// absorbs these and tready drops only when the queue is full.
// Reset is asynchronous and active low; it empties the queue and idles the matcher.
`timescale 1ns / 1ps

module xml_entity_decoder import xed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // end_of_text
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_unit
  output logic        m_axis_tlast,   // run_last: last result of one input word
  output logic        m_axis_tuser    // [0] text_done
);

  logic  accept;
  logic  push;
  logic  pop;
  logic  q_empty, q_full;
  desc_t desc_in, desc_head;

  // A word is taken whenever the burst queue has room. The decoder turns it
  // into a compact burst descriptor in the same cycle and updates its trie
  // node, so the next word can follow straight away.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  xed_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_unit_i (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .push_o      (push),
    .desc_o      (desc_in)
  );

  // The queue parts the two sides: the input keeps flowing while a long
  // burst drains at the output.
  xed_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (desc_in),
    .pop_i   (pop),
    .rdata_o (desc_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // The serialiser holds one descriptor and walks its flushes and its middle unit.
  // It loads the next descriptor in the cycle its last word is taken.
  xed_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (desc_head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .unit_o       (m_axis_tdata),
    .last_o       (m_axis_tlast),
    .done_o       (m_axis_tuser)
  );

endmodule

>>> hdl/xed_decode.sv
// Entity decoder front end: trie match state and burst descriptor build.
// Depends on xed_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "xml_entity_decoder_defines.svh"

module xed_decode import xed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [UnitW-1:0] code_unit_i,
  input  logic             eot_i,
  output logic             push_o,
  output desc_t            desc_o
);

  logic [NodeW-1:0] node_q, node_d;
  logic [NodeW-1:0] nxt;
  step_t            step;
  desc_t            d;

  always_comb begin
    step = trie_step(node_q, code_unit_i);
    d    = '0;
    nxt  = N_IDLE;
    d.eot = eot_i;
    if (node_q != N_IDLE && step.hit) begin
      if (step.done) begin
        d.mid_en   = 1'b1;
        d.mid_unit = {8'h00, step.emit};
      end else begin
        nxt = step.nxt;
      end
    end else begin
      // A failed prefix is flushed first; the unit is then taken from idle.
      if (node_q != N_IDLE) begin
        d.f1_node = node_q;
      end
      if (is_ch(code_unit_i, CH_AMP)) begin
        nxt = N_AMP;
      end else begin
        d.mid_en   = 1'b1;
        d.mid_unit = code_unit_i;
      end
    end
    if (eot_i && nxt != N_IDLE) begin
      d.f2_node = nxt;
      nxt       = N_IDLE;
    end
    node_d = accept_i ? nxt : node_q;
  end

  assign desc_o = d;
  assign push_o = accept_i && (d.f1_node != N_IDLE || d.mid_en || d.f2_node != N_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= N_IDLE;
    end else begin
      node_q <= node_d;
    end
  end

  `XED_ASSERT_NXT(a_eot_idle, accept_i && eot_i, node_q == N_IDLE, "open match after end of text")
  `XED_ASSERT_IMP(a_eot_push, accept_i && eot_i, push_o, "end of text gave no result")
  `XED_ASSERT_IMP(a_flush_order, push_o && desc_o.f1_node != N_IDLE && desc_o.f2_node != N_IDLE,
                  desc_o.f2_node == N_AMP && !desc_o.mid_en, "bad double flush")

endmodule

>>> hdl/xed_fifo.sv
// Small queue of burst descriptors between the decoder and the serialiser.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_fifo import xed_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t wdata_i,
  input  logic  pop_i,
  output desc_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);

  desc_t                mem_q [DescDepth];
  logic [DescPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [DescCntW-1:0]  cnt_q;
  logic                 do_push, do_pop;

  assign empty_o = cnt_q == DescCntW'(0);
  assign full_o  = cnt_q == DescCntW'(DescDepth);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + DescPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + DescPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + DescCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - DescCntW'(1);
      end
    end
  end

endmodule

>>> hdl/xed_serial.sv
// Serialiser: expands one burst descriptor into output words, one a cycle while ready_i is high.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_serial import xed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  desc_t            head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [UnitW-1:0] unit_o,
  output logic             last_o,
  output logic             done_o
);

  localparam logic [1:0] SEG_F1  = 2'd0;
  localparam logic [1:0] SEG_MID = 2'd1;
  localparam logic [1:0] SEG_F2  = 2'd2;

  desc_t            cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic [1:0]       seg_q, seg_d;
  logic [2:0]       pos_q, pos_d;
  logic [NodeW-1:0] fnode;
  logic [2:0]       hidx;
  logic [31:0]      hword;
  logic             seg_end, has_next, fire, load;
  logic [1:0]       next_seg, first_seg;

  always_comb begin
    fnode = (seg_q == SEG_F1) ? cur_q.f1_node : cur_q.f2_node;
    hword = held_word(fnode);
    hidx  = pos_q - 3'd3;
    unit_o = cur_q.mid_unit;
    unique case (pos_q)
      3'd0:    unit_o = {8'h00, CH_PCT};
      3'd1:    unit_o = {8'h00, CH_TWO};
      3'd2:    unit_o = {8'h00, CH_SIX};
      default: unit_o = {8'h00, hword[8*hidx[1:0] +: 8]};
    endcase
    if (seg_q == SEG_MID) begin
      unit_o = cur_q.mid_unit;
    end
    seg_end = (seg_q == SEG_MID) || (pos_q == held_len(fnode) + 3'd2);

    has_next = 1'b0;
    next_seg = SEG_F2;
    if (seg_q == SEG_F1 && cur_q.mid_en) begin
      has_next = 1'b1;
      next_seg = SEG_MID;
    end else if (seg_q != SEG_F2 && cur_q.f2_node != N_IDLE) begin
      has_next = 1'b1;
      next_seg = SEG_F2;
    end

    first_seg = (head_i.f1_node != N_IDLE) ? SEG_F1 :
                (head_i.mid_en ? SEG_MID : SEG_F2);
  end

  assign valid_o = cur_valid_q;
  assign last_o  = seg_end && !has_next;
  assign done_o  = last_o && cur_q.eot;
  assign fire    = cur_valid_q && ready_i;
  assign load    = head_valid_i && (!cur_valid_q || (fire && last_o));
  assign pop_o   = load;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    seg_d       = seg_q;
    pos_d       = pos_q;
    if (load) begin
      cur_d       = head_i;
      cur_valid_d = 1'b1;
      seg_d       = first_seg;
      pos_d       = 3'd0;
    end else if (fire) begin
      if (last_o) begin
        cur_valid_d = 1'b0;
      end else if (seg_end) begin
        seg_d = next_seg;
        pos_d = 3'd0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      seg_q       <= SEG_F1;
      pos_q       <= 3'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      seg_q       <= seg_d;
      pos_q       <= pos_d;
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the streaming XML entity decoder.
// It needs xed_pkg for its node-free character codes and the decoder RTL itself.
`timescale 1ns / 1ps

module testbench;
  import xed_pkg::*;

  // The watchdog gives up after this many cycles without a word moving on
  // either side. The slowest correct stretch is about a sender gap plus the
  // pipeline, or a ten-word burst behind receiver stalls, so this is generous.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 430;

  localparam logic [15:0] AMP_U  = {8'h00, CH_AMP};
  localparam logic [15:0] SEMI_U = {8'h00, CH_SEMI};

  // One expected output word, in the order of the output fields.
  typedef struct packed {
    logic [15:0] unit;
    logic        run_last;
    logic        text_done;
  } result_t;

  // One row of stimulus. Where typed is set, lit is the single result that
  // the word must give, written in by hand; otherwise the decoder model decides.
  typedef struct {
    logic [15:0] unit;
    logic        eot;
    bit          typed;
    logic [15:0] lit;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] code_unit
  logic        s_axis_tlast = 1'b0; // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] out_unit
  logic        m_axis_tlast;        // run_last
  logic        m_axis_tuser;        // [0] text_done

  always #4 clk_i = ~clk_i;

  xml_entity_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // The five entity names and the character that each one stands for.
  string      ent_name  [5] = '{"amp", "gt", "lt", "apos", "quot"};
  logic [7:0] ent_glyph [5] = '{CH_AMP, CH_GT, CH_LT, CH_APOS, CH_QUOT};

  // Decoder model state: whether an ampersand is held back, and the name
  // letters held after it. The model works on the held text itself rather
  // than on trie nodes, so it shares no structure with the design.
  bit          amp_open = 1'b0;
  logic [15:0] held_q[$];
  logic [15:0] burst_q[$];        // output units of the word being decoded
  result_t     due_results[$];    // decoded words not yet seen at the output

  stim_row_t   plan[$];
  int          fail_count = 0;
  int          n_words = 0;
  int          n_eot = 0;
  int          n_results = 0;
  int          n_entities = 0;
  int          n_replays = 0;
  int          send_calm = 0;
  int          recv_calm = 0;
  int          stall_cycles = 0;

  // A failed prefix comes out as "%26" followed by the letters held after
  // the ampersand; the model then returns to idle.
  function automatic void flush_held();
    burst_q.push_back({8'h00, CH_PCT});
    burst_q.push_back({8'h00, CH_TWO});
    burst_q.push_back({8'h00, CH_SIX});
    foreach (held_q[k]) burst_q.push_back(held_q[k]);
    held_q.delete();
    amp_open = 1'b0;
    n_replays++;
  endfunction

  // Decodes one input word into burst_q and moves the model state on.
  function automatic void decode_unit(logic [15:0] c, logic eot);
    int    i;
    int    k;
    bit    same;
    bit    grows;
    bit    closes;
    string nm;
    logic [15:0] glyph;
    burst_q.delete();
    grows  = 1'b0;
    closes = 1'b0;
    glyph  = '0;
    if (amp_open) begin
      // The held letters may be a prefix of several names (amp and apos);
      // the unit either extends one of them or closes one that is complete.
      for (i = 0; i < 5; i++) begin
        nm = ent_name[i];
        same = held_q.size() <= nm.len();
        for (k = 0; same && k < held_q.size(); k++)
          same = held_q[k] == {8'h00, nm[k]};
        if (same && held_q.size() < nm.len() && c == {8'h00, nm[held_q.size()]})
          grows = 1'b1;
        else if (same && held_q.size() == nm.len() && c == SEMI_U) begin
          closes = 1'b1;
          glyph  = {8'h00, ent_glyph[i]};
        end
      end
      if (closes) begin
        burst_q.push_back(glyph);
        held_q.delete();
        amp_open = 1'b0;
        n_entities++;
      end else if (grows) begin
        held_q.push_back(c);
      end else begin
        // The unit breaks the match: replay, then treat it as fresh text.
        flush_held();
      end
    end
    if (!amp_open && !closes && !grows) begin
      if (c == AMP_U)
        amp_open = 1'b1;
      else
        burst_q.push_back(c);
    end
    // At the end of the text nothing may stay held back.
    if (eot && amp_open)
      flush_held();
  endfunction

  function automatic void add_row(logic [15:0] u, logic eot, bit typed, logic [15:0] lit);
    stim_row_t r;
    r.unit  = u;
    r.eot   = eot;
    r.typed = typed;
    r.lit   = lit;
    plan.push_back(r);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++)
      add_row({8'h00, s[i]}, 1'b0, 1'b0, '0);
  endfunction

  function automatic logic eot_draw();
    return $urandom_range(0, 24) == 0;
  endfunction

  // Text noise: any unit at all, printable ASCII, the letters that matter to
  // the matcher, or such a letter with a non-zero high byte.
  function automatic logic [15:0] stray_unit();
    string      alpha = "&;amposgltqu";
    logic [7:0] hb;
    hb = 8'($urandom_range(1, 255));
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(16'h0020, 16'h007E));
      2: return {8'h00, alpha[$urandom_range(0, alpha.len() - 1)]};
      default: return {hb, alpha[$urandom_range(0, alpha.len() - 1)]};
    endcase
  endfunction

  // Idle cycles before the next word on one side, with the occasional long
  // stretch of back-to-back traffic.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Stimulus: build the plan, then drive it word by word. Each accepted word
  // is decoded by the model and its results are queued for the checker.
  initial begin : stimulus
    stim_row_t  r;
    result_t    res;
    int         idx;
    int         gap;
    int         n_directed;
    int         kind;
    int         pick;
    int         cut;
    int         p;
    int         k;
    int         n;
    bit         drain;
    string      nm;
    logic [15:0] u;
    logic [7:0] ch;
    logic [7:0] hb;

    // Directed words. The extremes of the unit pass straight through; the
    // second one also ends a text while nothing is held back.
    add_row(16'h0000, 1'b0, 1'b1, 16'h0000);
    add_row(16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
    // Each entity but quot decodes to its character on the semicolon.
    add_text("&amp");
    add_row(SEMI_U, 1'b0, 1'b1, {8'h00, CH_AMP});
    add_text("&gt");
    add_row(SEMI_U, 1'b0, 1'b1, {8'h00, CH_GT});
    add_text("&lt");
    add_row(SEMI_U, 1'b0, 1'b1, {8'h00, CH_LT});
    add_text("&apos");
    add_row(SEMI_U, 1'b0, 1'b1, {8'h00, CH_APOS});
    // The longest burst: a complete quot prefix broken by an ampersand that
    // is also the last unit of the text gives ten results.
    add_text("&quot");
    add_row(AMP_U, 1'b1, 1'b0, '0);
    // A letter with a non-zero high byte must not continue a match.
    add_row(AMP_U, 1'b0, 1'b0, '0);
    add_row(16'h8061, 1'b0, 1'b0, '0);
    n_directed = plan.size();

    // Random text: mostly entities and their prefixes with random breaks,
    // the rest noise and mangled names.
    while (plan.size() < n_directed + RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      pick = $urandom_range(0, 4);
      nm   = ent_name[pick];
      case (kind)
        0, 1, 2, 3: begin
          add_row(AMP_U, 1'b0, 1'b0, '0);
          add_text(nm);
          add_row(SEMI_U, eot_draw(), 1'b0, '0);
        end
        4, 5: begin
          cut = $urandom_range(0, nm.len());
          add_row(AMP_U, 1'b0, 1'b0, '0);
          for (k = 0; k < cut; k++)
            add_row({8'h00, nm[k]}, 1'b0, 1'b0, '0);
          // Either the text ends on the open prefix or a stray unit breaks it.
          if ($urandom_range(0, 5) == 0)
            plan[plan.size() - 1].eot = 1'b1;
          else
            add_row(stray_unit(), eot_draw(), 1'b0, '0);
        end
        6, 7: begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            add_row(stray_unit(), eot_draw(), 1'b0, '0);
        end
        8: begin
          // One letter of the name turned to a capital or given a high byte.
          p = $urandom_range(0, nm.len() - 1);
          add_row(AMP_U, 1'b0, 1'b0, '0);
          for (k = 0; k < nm.len(); k++) begin
            ch = nm[k];
            hb = 8'($urandom_range(1, 255));
            if (k != p)
              u = {8'h00, ch};
            else if ($urandom_range(0, 1) == 1)
              u = {8'h00, ch ^ 8'h20};
            else
              u = {hb, ch};
            add_row(u, 1'b0, 1'b0, '0);
          end
          add_row(SEMI_U, eot_draw(), 1'b0, '0);
        end
        default: begin
          add_row(AMP_U, 1'b0, 1'b0, '0);
          case ($urandom_range(0, 2))
            0: add_row(AMP_U, eot_draw(), 1'b0, '0);
            1: add_row(SEMI_U, eot_draw(), 1'b0, '0);
            default: add_row(stray_unit(), eot_draw(), 1'b0, '0);
          endcase
        end
      endcase
    end
    // Close the text so that nothing is left held back at the end.
    plan[plan.size() - 1].eot = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (idx = 0; idx < plan.size(); idx++) begin
      r   = plan[idx];
      gap = draw_gap(send_calm);
      // Hold off at the switch to random text, and now and then later, until
      // the output side has caught up completely.
      drain = (idx == n_directed) || ($urandom_range(0, 149) == 0);
      if (gap > 0 || drain)
        s_axis_tvalid <= 1'b0;
      if (drain) begin
        do @(posedge clk_i); while (due_results.size() != 0);
      end
      repeat (gap) @(posedge clk_i);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= r.unit;
      s_axis_tlast  <= r.eot;
      do @(posedge clk_i); while (!s_axis_tready);

      // The word was taken at this edge: work out what it must give.
      n_words++;
      if (r.eot)
        n_eot++;
      decode_unit(r.unit, r.eot);
      if (r.typed) begin
        burst_q.delete();
        burst_q.push_back(r.lit);
      end
      foreach (burst_q[j]) begin
        res.unit      = burst_q[j];
        res.run_last  = j == burst_q.size() - 1;
        res.text_done = res.run_last && r.eot;
        due_results.push_back(res);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the last bursts drain, then watch a little longer for strays.
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);

    $display("Covered %0d input words over %0d texts and %0d result words.",
             n_words, n_eot, n_results);
    $display("The model saw %0d entities decoded and %0d failed prefixes replayed.",
             n_entities, n_replays);
    if (fail_count == 0) begin
      $display("xml_entity_decoder test passed");
    end else begin
      $display("xml_entity_decoder test failed");
    end
    $finish;
  end

  // Output side: stall at random, then compare every word taken with the
  // oldest decoded word still owed.
  initial begin : result_check
    result_t want;
    int      gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      n_results++;
      if (due_results.size() == 0) begin
        $error("result word 0x%h arrived with nothing expected", m_axis_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata !== want.unit) begin
          $error("out_unit: expected 0x%h, got 0x%h", want.unit, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== want.text_done) begin
          $error("text_done: expected %b, got %b", want.text_done, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any word moving on either side proves progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("No word moved for %0d cycles; %0d results still owed.",
               STALL_LIMIT, due_results.size());
      $display("xml_entity_decoder test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

>>> xml_entity_decoder.f
+incdir+hdl
hdl/xed_pkg.sv
hdl/xed_decode.sv
hdl/xed_fifo.sv
hdl/xed_serial.sv
hdl/xml_entity_decoder.sv
tb/testbench.sv
